// ===== sv/xcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfr_pkg
// Types and constants shared by the XOR checksum frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_OK       = 2'd1;
  localparam logic [1:0] KIND_BAD_CSUM = 2'd2;
  localparam logic [1:0] KIND_BAD_STOP = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_RX_ENABLE    = 2'd0;
  localparam logic [1:0] REG_START_MARKER = 2'd1;
  localparam logic [1:0] REG_STOP_MARKER  = 2'd2;

  localparam logic [7:0] START_MARKER_RST = 8'h33;
  localparam logic [7:0] STOP_MARKER_RST  = 8'h99;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_DATA = 5'b00100,
    PH_CSUM = 5'b01000,
    PH_STOP = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       rx_enable;
    logic [7:0] start_marker;
    logic [7:0] stop_marker;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_position;
    logic [7:0] frame_length;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/xcfr_chan_if.sv =====
// ----------------------------------------------------------------------------
// xcfr_chan_if
// Valid/ready channel carrying one payload item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcfr_chan_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/xcfr_core.sv =====
// ----------------------------------------------------------------------------
// xcfr_core
// Frame state machine, length counter and running XOR; one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_core import xcfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output logic            res_valid,
  output out_item_t       res
);

  phase_t     phase, phase_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] bytes_received, bytes_received_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] count_inc;

  assign count_inc = bytes_received + 8'd1;

  always_comb begin
    phase_next           = phase;
    declared_length_next = declared_length;
    bytes_received_next  = bytes_received;
    running_xor_next     = running_xor;
    res_valid            = 1'b0;
    res.kind             = KIND_DATA;
    res.payload_byte     = '0;
    res.byte_position    = '0;
    res.frame_length     = declared_length;
    if (cfg.rx_enable) begin
      case (phase)
        PH_LEN: begin
          if (rx_byte == 8'd0) begin
            phase_next = PH_HUNT;
          end else begin
            declared_length_next = rx_byte;
            bytes_received_next  = '0;
            running_xor_next     = rx_byte;
            phase_next           = PH_DATA;
          end
        end
        PH_DATA: begin
          running_xor_next    = running_xor ^ rx_byte;
          bytes_received_next = count_inc;
          if (count_inc == declared_length) phase_next = PH_CSUM;
          res_valid         = 1'b1;
          res.payload_byte  = rx_byte;
          res.byte_position = bytes_received;
        end
        PH_CSUM: begin
          if (rx_byte == running_xor) begin
            phase_next = PH_STOP;
          end else begin
            phase_next = PH_HUNT;
            res_valid  = 1'b1;
            res.kind   = KIND_BAD_CSUM;
          end
        end
        PH_STOP: begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          res.kind   = (rx_byte == cfg.stop_marker) ? KIND_OK : KIND_BAD_STOP;
        end
        default: begin
          // hunt, and any stray code
          phase_next = (rx_byte == cfg.start_marker) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      declared_length <= '0;
      bytes_received  <= '0;
      running_xor     <= '0;
    end else if (step) begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      bytes_received  <= bytes_received_next;
      running_xor     <= running_xor_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xor_checksum_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// xor_checksum_frame_receiver
// Deframer for start / length / payload / XOR checksum / stop byte frames.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per beat. result carries one item per beat:
//   a payload byte (kind 0, with its position and the frame length) or a
//   verdict at the end of a frame (accepted, bad checksum, bad stop).
//   Downstream buffers payload beats and drops them on a reject verdict.
//   cfg_wr_en/cfg_index/cfg_data write the enable and the two marker bytes;
//   write only while no byte is in flight.
// Timing:
//   A byte is held in the input register, then the frame logic
//   updates its state and loads the result register, from which the
//   result is offered on the result channel.
//   One byte per cycle is sustained while result is not held off; the only
//   loop is the state update of the frame logic.
// Reset: frame logic returns to hunting for the start byte, both stages
//   empty, registers back to enabled, start 0x33, stop 0x99.
// Stall: while result is held off the result register keeps its item and
//   the input register holds its byte, whether or not that byte makes a
//   result; rx.ready falls when the input register is full behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checksum_frame_receiver import xcfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  xcfr_chan_if.sink       rx,
  xcfr_chan_if.source     result,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_valid;
  out_item_t  out_item;
  logic       out_free;
  logic       s1_step;
  logic       res_valid;
  out_item_t  res;

  assign out_free       = !out_valid || result.ready;
  assign s1_step        = s1_valid && out_free;
  assign rx.ready       = !s1_valid || out_free;
  assign result.valid   = out_valid;
  assign result.payload = out_item;

  xcfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_step),
    .rx_byte   (s1_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_enable    <= 1'b1;
      cfg.start_marker <= START_MARKER_RST;
      cfg.stop_marker  <= STOP_MARKER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RX_ENABLE:    cfg.rx_enable    <= cfg_data[0];
        REG_START_MARKER: cfg.start_marker <= cfg_data;
        REG_STOP_MARKER:  cfg.stop_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rx.ready) s1_valid <= rx.valid;
      if (out_free) out_valid <= s1_step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) s1_byte <= rx.payload.rx_byte;
    if (s1_step && res_valid) out_item <= res;
  end

endmodule

`default_nettype wire

// ===== sv/xcfr_checker.sv =====
// ----------------------------------------------------------------------------
// xcfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_checker import xcfr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result beat changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_DATA |->
      out_item.payload_byte == 8'd0 && out_item.byte_position == 8'd0)
    else $error("verdict beat carries payload fields");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_DATA |->
      out_item.byte_position < out_item.frame_length)
    else $error("payload position beyond frame length");

endmodule

bind xor_checksum_frame_receiver xcfr_checker u_xcfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_item  (result.payload)
);

`default_nettype wire
